// ----- rtl/mcwt_pkg.sv -----
// Shared types and constants for the multi-chip wake timer.
// No dependencies; imported by mcwt_core, multi_chip_wake_timer and tb_top.
package mcwt_pkg;

    localparam int CHIPS   = 3;
    localparam int TIMER_W = 24;
    localparam int SEL_W   = 2;
    localparam int TOP_BIT = TIMER_W - 1;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_WR_TIMER  = 2'd1,
        REQ_WR_ENABLE = 2'd2,
        REQ_ARM       = 2'd3
    } req_type_t;

    typedef logic [TIMER_W-1:0] timer_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [SEL_W-1:0]  chip_select;
        timer_t            write_value;
        logic              cpu_sleeping;
    } req_t;

    typedef struct packed {
        logic   service_request;
        logic   wake_condition;
        logic   wake_cpu;
        timer_t timer_readback;
    } res_t;

endpackage

// ----- rtl/mcwt_core.sv -----
// Per-chip timers, wake-enable bits, wake latches and the service flag,
// with the single-pass update for one beat. Depends on mcwt_pkg.
module mcwt_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  mcwt_pkg::req_t req,
    output mcwt_pkg::res_t result
);
    import mcwt_pkg::*;

    timer_t     timer_reg  [CHIPS];
    timer_t     timer_next [CHIPS];
    logic [CHIPS-1:0] enable_reg, enable_next;
    logic [CHIPS-1:0] armed_reg, armed_next;
    logic       service_reg, service_next;
    logic       wake;
    timer_t     readback;

    always_comb
    begin
        timer_t dec;
        logic   hit;
        logic   sreq;
        sreq         = 1'b0;
        wake         = 1'b0;
        readback     = '0;
        enable_next  = enable_reg;
        armed_next   = armed_reg;
        service_next = service_reg;
        for (int i = 0; i < CHIPS; i++)
        begin
            timer_next[i] = timer_reg[i];
            dec = timer_reg[i] - timer_t'(1);
            hit = (int'(req.chip_select) == i);
            unique case (req.req_type)
                REQ_TICK:
                begin
                    timer_next[i] = dec;
                    if (dec[TOP_BIT] && enable_reg[i])
                        sreq = 1'b1;
                    if (dec[TOP_BIT] && (!timer_reg[i][TOP_BIT] || armed_reg[i]))
                        wake = 1'b1;
                    // latch drops whenever the top bit is set after the tick
                    if (dec[TOP_BIT])
                        armed_next[i] = 1'b0;
                end
                REQ_WR_TIMER:
                begin
                    if (hit)
                        timer_next[i] = req.write_value;
                end
                REQ_WR_ENABLE:
                begin
                    if (hit)
                        enable_next[i] = req.write_value[0];
                end
                REQ_ARM:
                begin
                    if (hit)
                        armed_next[i] = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (hit)
                readback = timer_next[i];
        end
        if (req.req_type == REQ_TICK)
            service_next = sreq;
    end

    assign result.service_request = service_next;
    assign result.wake_condition  = wake;
    assign result.wake_cpu        = wake & req.cpu_sleeping;
    assign result.timer_readback  = readback;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHIPS; i++)
                timer_reg[i] <= '0;
            enable_reg  <= '0;
            armed_reg   <= '0;
            service_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < CHIPS; i++)
                timer_reg[i] <= timer_next[i];
            enable_reg  <= enable_next;
            armed_reg   <= armed_next;
            service_reg <= service_next;
        end
    end

endmodule

// ----- rtl/multi_chip_wake_timer.sv -----
// Top level of the multi-chip wake timer: input register, output register
// and handshake. Depends on mcwt_pkg and mcwt_core.
//
//  channel | valid / stall        | beat fields
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | req_type, chip_select, write_value,
//          |                      | cpu_sleeping
//  out     | out_valid / out_stall| service_request, wake_condition, wake_cpu,
//          |                      | timer_readback
//
// One beat per cycle sustained while out_stall is low. A beat is captured in
// the input register, goes through the core's single pass (decrement and
// compare per chip) and lands in the output register.
// The state updates when the beat moves into the output register, so the next
// beat sees it at once. rst_n clears timers, enables, latches, service flag
// and both valid bits. out_stall holds the output register; the input register
// then holds too and in_stall rises only while it is full and blocked.
module multi_chip_wake_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [mcwt_pkg::SEL_W-1:0]    chip_select,
    input  logic [mcwt_pkg::TIMER_W-1:0]  write_value,
    input  logic                          cpu_sleeping,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          service_request,
    output logic                          wake_condition,
    output logic                          wake_cpu,
    output logic [mcwt_pkg::TIMER_W-1:0]  timer_readback
);
    import mcwt_pkg::*;

    logic in_valid_reg;
    req_t req_reg;
    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;
    logic out_free;
    logic advance;
    logic in_take;

    // output register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    mcwt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.req_type     <= req_type_t'(req_type);
            req_reg.chip_select  <= chip_select;
            req_reg.write_value  <= write_value;
            req_reg.cpu_sleeping <= cpu_sleeping;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign service_request = res_reg.service_request;
    assign wake_condition  = res_reg.wake_condition;
    assign wake_cpu        = res_reg.wake_cpu;
    assign timer_readback  = res_reg.timer_readback;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for multi_chip_wake_timer: queue-fed driver, clocked
// monitor and an in-line predictor of timers, wake latches and service flag.
// Depends on mcwt_pkg and the multi_chip_wake_timer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcwt_pkg::*;

    // Run shape
    localparam int RAND_ITEMS  = 850;
    localparam int TAIL_ITEMS  = 120;   // last beats run with no idling
    localparam int DRAIN_AT    = 600;   // sender waits for all results first
    localparam int HOLD_AT     = 300;   // receiver long hold-off starts here
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE      = 8;     // input and output registers plus margin
    localparam int LIMIT       = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          req_type = 2'd0;
    logic [SEL_W-1:0]    chip_select = '0;
    logic [TIMER_W-1:0]  write_value = '0;
    logic                cpu_sleeping = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                service_request;
    logic                wake_condition;
    logic                wake_cpu;
    logic [TIMER_W-1:0]  timer_readback;

    multi_chip_wake_timer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .chip_select     (chip_select),
        .write_value     (write_value),
        .cpu_sleeping    (cpu_sleeping),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .service_request (service_request),
        .wake_condition  (wake_condition),
        .wake_cpu        (wake_cpu),
        .timer_readback  (timer_readback)
    );

    // Beats waiting to be offered, and results owed by the block, oldest first.
    req_t pending_q[$];
    res_t owed_results_q[$];

    int stim_total   = 0;
    int sent_cnt     = 0;
    int accepted_cnt = 0;
    int result_cnt   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    req_t cur_beat;

    // Predictor state: mirror of the per-chip timers, enables and latches.
    timer_t shadow_timer  [CHIPS];
    logic   shadow_enable [CHIPS];
    logic   shadow_armed  [CHIPS];
    logic   shadow_sreq;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor. Applies one beat to the shadow state and returns the
    // result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic res_t timer_update(req_t b);
        res_t        r;
        int unsigned sel;
        logic        in_range;
        logic        was_top;
        logic        now_top;
        logic        sreq;
        logic        wake;
        sel      = 32'(b.chip_select);
        in_range = (sel < CHIPS);
        wake     = 1'b0;
        sreq     = 1'b0;
        case (b.req_type)
            REQ_TICK:
            begin
                // All timers count down together; bit 23 acts as the
                // "expired" marker. A wake needs a fresh crossing into the
                // top half, or an armed latch on a chip already there.
                for (int i = 0; i < CHIPS; i++)
                begin
                    was_top = shadow_timer[i][TOP_BIT];
                    shadow_timer[i] = shadow_timer[i] - timer_t'(1);
                    now_top = shadow_timer[i][TOP_BIT];
                    if (now_top && shadow_enable[i])
                        sreq = 1'b1;
                    if (now_top && (!was_top || shadow_armed[i]))
                    begin
                        shadow_armed[i] = 1'b0;
                        wake = 1'b1;
                    end
                end
                shadow_sreq = sreq;
            end
            REQ_WR_TIMER:
                if (in_range)
                    shadow_timer[sel] = b.write_value;
            REQ_WR_ENABLE:
                if (in_range)
                    shadow_enable[sel] = b.write_value[0];
            default:
                if (in_range)
                    shadow_armed[sel] = 1'b1;
        endcase
        // Non-tick beats report no wake and keep the last service request.
        r.service_request = shadow_sreq;
        r.wake_condition  = wake;
        r.wake_cpu        = wake & b.cpu_sleeping;
        r.timer_readback  = in_range ? shadow_timer[sel] : '0;
        return r;
    endfunction

    task automatic add_beat(req_type_t t, int sel, timer_t v, bit sleeping);
        req_t b;
        b.req_type     = t;
        b.chip_select  = sel[SEL_W-1:0];
        b.write_value  = v;
        b.cpu_sleeping = sleeping;
        pending_q.push_back(b);
    endtask

    // Timer values around the wrap point and the top-bit boundary, where ticks
    // actually change the wake and service outputs, plus fully random values.
    function automatic timer_t pick_timer();
        timer_t v;
        case ($urandom_range(0, 5))
            0:       v = timer_t'($urandom_range(0, 3));
            1:       v = timer_t'(24'h800000 + $urandom_range(0, 3));
            2:       v = timer_t'(24'h7FFFFF - $urandom_range(0, 2));
            3:       v = timer_t'(24'hFFFFFF - $urandom_range(0, 2));
            default: v = timer_t'($urandom());
        endcase
        return v;
    endfunction

    task automatic mismatch(string what, logic [TIMER_W-1:0] want,
                            logic [TIMER_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch: %s at result %0d, expected %h got %h",
                     what, result_cnt, want, got);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int sel;
        int ticks;
        for (int i = 0; i < CHIPS; i++)
        begin
            shadow_timer[i]  = '0;
            shadow_enable[i] = 1'b0;
            shadow_armed[i]  = 1'b0;
        end
        shadow_sreq = 1'b0;

        // Directed: wrap out of reset, armed latch, service request,
        // out-of-range chip select, extreme timer values.
        add_beat(REQ_TICK,      0, 24'h000000, 1'b1);  // 0 -> FFFFFF: wake
        add_beat(REQ_TICK,      1, 24'hFFFFFF, 1'b0);  // already top: no wake
        add_beat(REQ_ARM,       0, 24'h000000, 1'b0);
        add_beat(REQ_ARM,       0, 24'hFFFFFF, 1'b0);  // re-arm stays armed
        add_beat(REQ_TICK,      0, 24'h000000, 1'b1);  // armed latch fires
        add_beat(REQ_WR_ENABLE, 2, 24'h000001, 1'b0);
        add_beat(REQ_TICK,      2, 24'h000000, 1'b1);  // service request rises
        add_beat(REQ_WR_ENABLE, 3, 24'h000001, 1'b0);  // chip 3 does not exist
        add_beat(REQ_WR_TIMER,  3, 24'hFFFFFF, 1'b1);
        add_beat(REQ_ARM,       3, 24'h000000, 1'b0);
        add_beat(REQ_WR_TIMER,  0, 24'h000000, 1'b0);
        add_beat(REQ_WR_TIMER,  1, 24'h800000, 1'b0);
        add_beat(REQ_WR_TIMER,  2, 24'hFFFFFF, 1'b0);
        add_beat(REQ_WR_ENABLE, 1, 24'hFFFFFE, 1'b1);  // only bit 0 counts
        add_beat(REQ_TICK,      1, 24'h000000, 1'b1);
        add_beat(REQ_WR_ENABLE, 2, 24'h000000, 1'b0);
        add_beat(REQ_TICK,      2, 24'h000000, 1'b0);  // service request drops
        add_beat(REQ_WR_TIMER,  1, 24'h800001, 1'b1);
        add_beat(REQ_ARM,       1, 24'h000000, 1'b1);
        add_beat(REQ_TICK,      1, 24'hFFFFFF, 1'b1);  // armed, stays top
        add_beat(REQ_WR_TIMER,  0, 24'hFFFFFF, 1'b0);
        add_beat(REQ_TICK,      0, 24'hFFFFFF, 1'b1);

        // Random: mostly load/enable/arm/tick sequences on one chip, the rest
        // single beats of any kind with fully random fields.
        while (pending_q.size() < RAND_ITEMS + 22)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                sel = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, CHIPS - 1);
                add_beat(REQ_WR_TIMER, sel, pick_timer(), bit'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    add_beat(REQ_WR_ENABLE, sel, timer_t'($urandom()),
                             bit'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    add_beat(REQ_ARM, sel, timer_t'($urandom()),
                             bit'($urandom_range(0, 1)));
                ticks = $urandom_range(1, 4);
                for (int t = 0; t < ticks; t++)
                    add_beat(REQ_TICK, $urandom_range(0, 3), timer_t'($urandom()),
                             bit'($urandom_range(0, 1)));
            end
            else
                add_beat(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 3),
                         timer_t'($urandom()), bit'($urandom_range(0, 1)));
        end
        stim_total = pending_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != stim_total || owed_results_q.size() != 0)
            @(posedge clk);
        // Catch any stray beat the block might still push out.
        repeat (SETTLE) @(posedge clk);

        if (mismatch_cnt == 0 && owed_results_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. Predicts on acceptance, holds a stalled beat unchanged, then
    // idles for a burst, waits at the drain point, or offers the next pending beat.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit fire;
        bit tail;
        if (rst_n)
        begin
            fire = in_valid && !in_stall;
            if (fire)
            begin
                owed_results_q.push_back(timer_update(cur_beat));
                accepted_cnt++;
            end
            tail = (sent_cnt >= stim_total - TAIL_ITEMS);
            if (!in_valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                    in_valid <= 1'b0;
                else if (sent_cnt == DRAIN_AT && (fire || owed_results_q.size() != 0))
                    in_valid <= 1'b0;   // pause until the block has emptied
                else
                begin
                    cur_beat = pending_q.pop_front();
                    sent_cnt++;
                    in_valid     <= 1'b1;
                    req_type     <= cur_beat.req_type;
                    chip_select  <= cur_beat.chip_select;
                    write_value  <= cur_beat.write_value;
                    cpu_sleeping <= cur_beat.cpu_sleeping;
                    if (!tail && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end
            end
        end
    end

    // Long receiver hold-off, timed here, so the input side backs up while
    // the driver keeps offering beats.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Checks each accepted result beat against the oldest owed
    // result, field by field, then picks the next stall value.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        bit   tail;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results_q.size() == 0)
                    mismatch("result beat with nothing owed", '0, timer_readback);
                else
                begin
                    want = owed_results_q.pop_front();
                    if (service_request !== want.service_request)
                        mismatch("service_request", TIMER_W'(want.service_request),
                                 TIMER_W'(service_request));
                    if (wake_condition !== want.wake_condition)
                        mismatch("wake_condition", TIMER_W'(want.wake_condition),
                                 TIMER_W'(wake_condition));
                    if (wake_cpu !== want.wake_cpu)
                        mismatch("wake_cpu", TIMER_W'(want.wake_cpu), TIMER_W'(wake_cpu));
                    if (timer_readback !== want.timer_readback)
                        mismatch("timer_readback", want.timer_readback, timer_readback);
                end
                result_cnt++;
            end
            tail = (sent_cnt >= stim_total - TAIL_ITEMS);
            if (hold_left != 0)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!tail && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 6);
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/mcwt_pkg.sv
rtl/mcwt_core.sv
rtl/multi_chip_wake_timer.sv
test/tb_top.sv
